// ===== design/cfgnms_pkg.sv =====
// ----------------------------------------------------------------------------
// cfgnms_pkg: shared constants and types
// Sizes, register indexes and the packed entry layout of the NMS block.
// ----------------------------------------------------------------------------
package cfgnms_pkg;
    localparam int MAX_BOXES = 64;
    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int GEO_W = 62;
    localparam int ENT_W = GEO_W + 12 + 1 + 1;
    localparam logic [0:0] REG_TARGET_CLASS = 1'b0;
    localparam logic [0:0] REG_IOU_THRESHOLD = 1'b1;

    // IoU comparison request passed to the test unit
    typedef struct packed {
        logic        start;
        logic [GEO_W-1:0] geo_a;
        logic [GEO_W-1:0] geo_b;
    } t_iou_req;
endpackage

// ===== design/cfgnms_ram.sv =====
// ----------------------------------------------------------------------------
// cfgnms_ram: generic single-port RAM
// One access per cycle at a single address (a write also reads the old word); read data registered.
// ----------------------------------------------------------------------------
module cfgnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== design/cfgnms_iou.sv =====
// ----------------------------------------------------------------------------
// cfgnms_iou: pipelined overlap test
// Four stages: overlap and areas, intersection, union, products; the compare is combinational.
// ----------------------------------------------------------------------------
module cfgnms_iou (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cfgnms_pkg::t_iou_req     i_req,
    input  logic [16:0]              i_thr,
    output logic                     o_done,
    output logic                     o_close
);
    logic [3:0] r_vld;
    logic signed [17:0] r_iw, r_ih;
    logic [29:0] r_a0, r_a1;
    logic [29:0] r_inter;
    logic [29:0] r_a0b, r_a1b;
    logic signed [32:0] r_uni;
    logic [29:0] r_inter2;
    logic [47:0] r_lhs;
    logic signed [51:0] r_rhs;

    logic signed [17:0] x0, y0, x1, y1, r0, r1, b0, b1, iw, ih;
    logic [14:0] w0, h0, w1, h1;

    always_comb begin
        x0 = 18'(signed'(i_req.geo_a[15:0]));
        y0 = 18'(signed'(i_req.geo_a[31:16]));
        w0 = i_req.geo_a[46:32];
        h0 = i_req.geo_a[61:47];
        x1 = 18'(signed'(i_req.geo_b[15:0]));
        y1 = 18'(signed'(i_req.geo_b[31:16]));
        w1 = i_req.geo_b[46:32];
        h1 = i_req.geo_b[61:47];
        r0 = x0 + signed'({3'b0, w0});
        r1 = x1 + signed'({3'b0, w1});
        b0 = y0 + signed'({3'b0, h0});
        b1 = y1 + signed'({3'b0, h1});
        iw = ((r0 < r1) ? r0 : r1) - ((x0 > x1) ? x0 : x1);
        ih = ((b0 < b1) ? b0 : b1) - ((y0 > y1) ? y0 : y1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_req.start};
        end
        // stage 1: clamp overlap, areas
        r_iw <= iw[17] ? 18'sd0 : iw;
        r_ih <= ih[17] ? 18'sd0 : ih;
        r_a0 <= w0 * h0;
        r_a1 <= w1 * h1;
        // stage 2: intersection
        r_inter <= 30'(r_iw[15:0] * r_ih[15:0]);
        r_a0b <= r_a0;
        r_a1b <= r_a1;
        // stage 3: union, intersection carried along
        r_uni <= 33'(signed'({1'b0, r_a0b}) + signed'({1'b0, r_a1b})
                 - signed'({1'b0, r_inter}));
        r_inter2 <= r_inter;
        // stage 4 prepared below in two halves
        r_lhs <= {r_inter2, 16'b0, 2'b0} >> 2;
        r_rhs <= 52'(signed'({1'b0, i_thr}) * r_uni);
    end

    logic r_uni_pos;
    always_ff @(posedge i_clk) begin
        r_uni_pos <= (r_uni > 33'sd0);
    end

    assign o_done  = r_vld[3];
    assign o_close = r_uni_pos && (signed'({4'b0, r_lhs}) > r_rhs);
endmodule

// ===== design/class_filtered_greedy_nms_top.sv =====
// ----------------------------------------------------------------------------
// class_filtered_greedy_nms_top: class-filtered greedy NMS
// Stores ranked boxes, suppresses overlaps of the target class, emits ranks.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one candidate box per request, best rank first; tlast
//   closes the set. Up to MAX_BOXES boxes are kept; later ones are dropped
//   and the overflow flag is raised on every result of that set.
//   After the closing request the block walks all pairs (i, j>i) of
//   surviving target-class entries through a four-stage overlap unit,
//   reading entry j from the entry RAM each pair: a pair examined goes
//   through read, check and a wait for the overlap result; a skipped j
//   takes read and check only; an outer entry that cannot suppress is
//   passed over. Then one result per stored entry is sent in rank order
//   on the master stream, each after a RAM read; tlast marks the last.
//   Boxes load at one per cycle; input is refused during suppress and emit.
//   A stalled receiver simply holds the current result.
//   Reset (synchronous, active low) empties the store, clears overflow and
//   loads the register reset values; RAM contents need no clearing.
//   A closing request with an empty store is itself stored and gives a single result.
// ----------------------------------------------------------------------------
module class_filtered_greedy_nms_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // box_index[11:0], entry_valid[12], class_id[20:13], box_x[36:21],
    // box_y[52:37], box_w[67:53], box_h[82:68], zero fill to 88
    input  logic [87:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ranked_index[11:0], kept[12], overflow[13], zero fill to 16
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    localparam int AW = cfgnms_pkg::AW;
    localparam int CW = cfgnms_pkg::CW;
    localparam int EW = cfgnms_pkg::ENT_W;
    localparam int GW = cfgnms_pkg::GEO_W;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_RDI  = 3'd1; // read outer entry
    localparam logic [2:0] S_RDJ  = 3'd2; // read inner entry
    localparam logic [2:0] S_CHK  = 3'd3; // decide inner entry
    localparam logic [2:0] S_WAIT = 3'd4; // wait for overlap result
    localparam logic [2:0] S_ERD  = 3'd5; // read entry to emit
    localparam logic [2:0] S_EOUT = 3'd6; // offer result

    logic [2:0]    r_state;
    logic [7:0]    r_tclass;
    logic [16:0]   r_thr;
    logic [CW-1:0] r_count;
    logic          r_drop;
    logic [AW-1:0] r_i, r_j;
    logic [GW-1:0] r_geo_i;
    logic          r_out_vld;
    logic [15:0]   r_out_data;
    logic          r_out_last;

    // RAM entry: geometry, index, alive, in class
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [EW-1:0] ram_wdata, ram_rdata;
    logic [EW-1:0] in_entry;

    logic [GW-1:0] rd_geo;
    logic [11:0]   rd_idx;
    logic          rd_alive, rd_cls;
    assign rd_geo   = ram_rdata[GW-1:0];
    assign rd_idx   = ram_rdata[GW+11:GW];
    assign rd_alive = ram_rdata[GW+12];
    assign rd_cls   = ram_rdata[GW+13];

    assign in_entry = {(s_axis_tdata[20:13] == r_tclass), s_axis_tdata[12],
                       s_axis_tdata[11:0], s_axis_tdata[82:68],
                       s_axis_tdata[67:53], s_axis_tdata[52:21]};

    cfgnms_pkg::t_iou_req iou_req;
    logic iou_done, iou_close;

    logic accept;
    assign s_axis_tready = (r_state == S_LOAD);
    assign accept = s_axis_tvalid && s_axis_tready;

    logic full;
    assign full = (r_count == CW'(cfgnms_pkg::MAX_BOXES));
    logic [CW-1:0] i_next, j_next;
    assign i_next = CW'(r_i) + 1'b1;
    assign j_next = CW'(r_j) + 1'b1;

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_count[AW-1:0];
        ram_wdata = in_entry;
        iou_req.start = 1'b0;
        iou_req.geo_a = r_geo_i;
        iou_req.geo_b = rd_geo;
        case (r_state)
            S_LOAD: begin
                ram_we = accept && !full;
            end
            S_RDI: ram_addr = r_i;
            S_RDJ: ram_addr = r_j;
            S_CHK: begin
                ram_addr = r_j;
                iou_req.start = rd_alive && rd_cls;
            end
            S_WAIT: begin
                ram_addr  = r_j;
                ram_wdata = {rd_cls, 1'b0, rd_idx, rd_geo};
                ram_we    = iou_done && iou_close;
            end
            S_ERD:  ram_addr = r_i;
            S_EOUT: ram_addr = r_i;
            default: ram_addr = r_i;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_tclass  <= 8'd0;
            r_thr     <= 17'd29491;
            r_count   <= '0;
            r_drop    <= 1'b0;
            r_out_vld <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cfgnms_pkg::REG_TARGET_CLASS:  r_tclass <= i_cfg_wdata[7:0];
                    cfgnms_pkg::REG_IOU_THRESHOLD: r_thr <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_out_vld && m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (full) r_drop <= 1'b1;
                        else      r_count <= r_count + 1'b1;
                        if (s_axis_tlast) begin
                            r_i <= '0;
                            if (r_count == '0 && full) begin
                                r_state <= S_LOAD;
                            end else if (r_count == '0 && !full) begin
                                r_state <= S_ERD; // single entry
                            end else begin
                                r_state <= S_RDI;
                            end
                        end
                    end
                end
                S_RDI: begin
                    // skip outer ranks that cannot suppress; last rank ends pass
                    if (i_next >= r_count) begin
                        r_i <= '0;
                        r_state <= S_ERD;
                    end else begin
                        r_j <= r_i + 1'b1;
                        r_state <= S_RDJ;
                    end
                end
                S_RDJ: begin
                    if (r_j == r_i + 1'b1) begin
                        // data of outer entry arrives now
                        r_geo_i <= rd_geo;
                        if (!(rd_alive && rd_cls)) begin
                            r_i <= r_i + 1'b1;
                            r_state <= S_RDI;
                        end else begin
                            r_state <= S_CHK;
                        end
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (rd_alive && rd_cls) begin
                        r_state <= S_WAIT;
                    end else if (j_next >= r_count) begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_RDI;
                    end else begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_RDJ;
                    end
                end
                S_WAIT: begin
                    if (iou_done) begin
                        if (j_next >= r_count) begin
                            r_i <= r_i + 1'b1;
                            r_state <= S_RDI;
                        end else begin
                            r_j <= r_j + 1'b1;
                            r_state <= S_RDJ;
                        end
                    end
                end
                S_ERD: begin
                    if (!r_out_vld || m_axis_tready) begin
                        r_state <= S_EOUT;
                    end
                end
                S_EOUT: begin
                    r_out_vld  <= 1'b1;
                    r_out_data <= {2'b0, r_drop, rd_alive, rd_idx};
                    r_out_last <= (i_next == r_count);
                    if (i_next == r_count) begin
                        r_count <= '0;
                        r_drop  <= 1'b0;
                        r_state <= S_LOAD;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_ERD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // read data stays valid in S_WAIT: address held at r_j, no write until done

    cfgnms_ram #(.WIDTH(EW), .DEPTH(cfgnms_pkg::MAX_BOXES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    cfgnms_iou u_iou (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (iou_req),
        .i_thr   (r_thr),
        .o_done  (iou_done),
        .o_close (iou_close)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // store never exceeds capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(cfgnms_pkg::MAX_BOXES))
        else $error("entry count beyond capacity");
    // no input taken outside loading
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !s_axis_tready)
        else $error("input ready outside load");
    // held result is not overwritten while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !m_axis_tready) |=> $stable(r_out_data))
        else $error("stalled result changed");
endmodule
